/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed: label");

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed: label");

`endif

/* design/rsf_pkg.sv */
`default_nettype none

package rsf_pkg;

   localparam logic [7:0] SLIP_END     = 8'hC0;
   localparam logic [7:0] SLIP_ESC     = 8'hDB;
   localparam logic [7:0] SLIP_ESC_END = 8'hDC;
   localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

   localparam logic [1:0] OP_ACTIVE = 2'd0;
   localparam logic [1:0] OP_DATA   = 2'd1;
   localparam logic [1:0] OP_ERROR  = 2'd2;

   localparam int MAX_BYTES = 9;
   localparam int COUNT_W   = $clog2(MAX_BYTES + 1);
   localparam int NUM_SEGS  = 5;

   typedef struct packed {
      logic [1:0]  operation;
      logic [11:0] bus_pins;
      logic [31:0] timestamp_ms;
      logic        line_still_active;
      logic        data_pending;
   } rsf_item_type;

   // bytes of one event, in send order from entry 0
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [COUNT_W-1:0]        count;
      logic                      flush;
      logic                      err;
   } rsf_burst_type;

   // one escaped byte: one or two output bytes, or none
   typedef struct packed {
      logic [1:0] len;
      logic [7:0] b0;
      logic [7:0] b1;
   } rsf_seg_type;

   function automatic rsf_seg_type slip_escape(input logic [7:0] b);
      rsf_seg_type s;
      s.len = 2'd1;
      s.b0  = b;
      s.b1  = 8'h00;
      if (b == SLIP_END) begin
         s.len = 2'd2;
         s.b0  = SLIP_ESC;
         s.b1  = SLIP_ESC_END;
      end else if (b == SLIP_ESC) begin
         s.len = 2'd2;
         s.b0  = SLIP_ESC;
         s.b1  = SLIP_ESC_ESC;
      end
      return s;
   endfunction

   function automatic rsf_seg_type slip_raw(input logic [7:0] b);
      rsf_seg_type s;
      s.len = 2'd1;
      s.b0  = b;
      s.b1  = 8'h00;
      return s;
   endfunction

   // bus pins to 10-bit word; pins 4 and 5 unused
   function automatic logic [9:0] unscramble(input logic [11:0] p);
      return {p[9:8], p[11:10], p[0], p[1], p[6], p[7], p[3:2]};
   endfunction

endpackage

`default_nettype wire

/* design/rsf_ifs.sv */
`default_nettype none

interface rsf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [11:0] bus_pins;
   logic [31:0] timestamp_ms;
   logic        line_still_active;
   logic        data_pending;

   modport source (output valid, output operation, output bus_pins, output timestamp_ms,
                   output line_still_active, output data_pending, input ready);
   modport sink (input valid, input operation, input bus_pins, input timestamp_ms,
                 input line_still_active, input data_pending, output ready);
endinterface

interface rsf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_byte;
   logic       flush_read;
   logic       reset_pulse;

   modport source (output valid, output out_byte, output last_byte, output flush_read,
                   output reset_pulse, input ready);
   modport sink (input valid, input out_byte, input last_byte, input flush_read,
                 input reset_pulse, output ready);
endinterface

interface rsf_csr_if;
   logic valid;
   logic ready;
   logic receive_enable;

   modport source (output valid, output receive_enable, input ready);
   modport sink (input valid, input receive_enable, output ready);
endinterface

`default_nettype wire

/* design/rsf_expand.sv */
`default_nettype none

module rsf_expand
   import rsf_pkg::*;
(
   input  rsf_item_type  item,
   input  logic          enable,
   input  logic          in_frame,
   output rsf_burst_type burst,
   output logic          in_frame_next
);

   logic [9:0]             word;
   logic [15:0]            value;
   rsf_seg_type [NUM_SEGS-1:0] segs;
   logic [COUNT_W-1:0]     pos;
   logic                   flush;
   logic                   err;

   assign word  = unscramble(item.bus_pins);
   assign value = {(item.operation == OP_ERROR), 5'd0, word};

   // pick the segments for this event and the next frame state
   always_comb begin
      segs          = '0;
      flush         = 1'b0;
      err           = 1'b0;
      in_frame_next = in_frame;
      if (enable) begin
         if (item.operation == OP_ACTIVE && !in_frame) begin
            segs[0]       = slip_raw(SLIP_END);
            segs[1]       = slip_escape(item.timestamp_ms[7:0]);
            segs[2]       = slip_escape(item.timestamp_ms[15:8]);
            segs[3]       = slip_escape(item.timestamp_ms[23:16]);
            segs[4]       = slip_escape(item.timestamp_ms[31:24]);
            flush         = item.data_pending;
            in_frame_next = 1'b1;
         end else if (item.operation == OP_DATA && in_frame) begin
            segs[0] = slip_escape(value[7:0]);
            segs[1] = slip_escape(value[15:8]);
            if (!item.line_still_active && !item.data_pending) begin
               segs[2]       = slip_raw(SLIP_END);
               in_frame_next = 1'b0;
            end
         end else if (item.operation == OP_ERROR && in_frame) begin
            segs[0] = slip_escape(value[7:0]);
            segs[1] = slip_escape(value[15:8]);
            err     = 1'b1;
         end
      end
   end

   // pack the segments back to back
   always_comb begin
      burst.bytes = '0;
      burst.flush = flush;
      burst.err   = err;
      pos         = '0;
      for (int s = 0; s < NUM_SEGS; s++) begin
         if (segs[s].len != 2'd0) begin
            burst.bytes[pos] = segs[s].b0;
         end
         if (segs[s].len == 2'd2) begin
            burst.bytes[pos + COUNT_W'(1)] = segs[s].b1;
         end
         pos = pos + COUNT_W'(segs[s].len);
      end
      burst.count = pos;
   end

endmodule

`default_nettype wire

/* design/rsf_emit.sv */
`default_nettype none

module rsf_emit
   import rsf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rsf_burst_type burst,
   output logic          free,
   rsf_rsp_if.source     rsp_chan
);

   logic [MAX_BYTES-1:0][7:0] bytes_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic                      flush_ff;
   logic                      err_ff;
   logic                      pop;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign free = (count_ff == '0) || (count_ff == COUNT_W'(1) && rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= burst.count;
      end else if (pop) begin
         count_ff <= count_ff - COUNT_W'(1);
      end
   end

   // advance one byte per accepted word; flush only rides on the first
   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= burst.bytes;
         flush_ff <= burst.flush;
         err_ff   <= burst.err;
      end else if (pop) begin
         bytes_ff <= {8'h00, bytes_ff[MAX_BYTES-1:1]};
         flush_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.out_byte    = bytes_ff[0];
   assign rsp_chan.last_byte   = (count_ff == COUNT_W'(1));
   assign rsp_chan.flush_read  = flush_ff;
   assign rsp_chan.reset_pulse = err_ff && (count_ff == COUNT_W'(1));

endmodule

`default_nettype wire

/* design/receive_event_slip_framer_core.sv */
// Receive event SLIP framer. Each event word on req_chan is taken into an input
// register, expanded in one pass into its SLIP bytes (END plus a 4-byte escaped
// timestamp when a frame opens, two escaped word bytes for data or error, and a
// closing END when the line drops with nothing pending), and sent one byte per
// rsp_chan word. An event gives 2 to 9 bytes, or none at all. The next
// event is taken while the current one's bytes drain. Writing csr_chan sets the
// enable and closes any open frame; write it only when the block is idle.
`default_nettype none

module receive_event_slip_framer_core
   import rsf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   rsf_req_if.sink   req_chan,
   rsf_rsp_if.source rsp_chan,
   rsf_csr_if.sink   csr_chan
);

   rsf_item_type  item_ff;
   logic          item_valid_ff;
   logic          enable_ff;
   logic          in_frame_ff;
   logic          in_frame_in;
   logic          free;
   logic          load;
   logic          take;
   rsf_burst_type burst;

   assign load           = item_valid_ff && free;
   assign req_chan.ready = !item_valid_ff || free;
   assign take           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (take) begin
         item_valid_ff <= 1'b1;
      end else if (load) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.operation         <= req_chan.operation;
         item_ff.bus_pins          <= req_chan.bus_pins;
         item_ff.timestamp_ms      <= req_chan.timestamp_ms;
         item_ff.line_still_active <= req_chan.line_still_active;
         item_ff.data_pending      <= req_chan.data_pending;
      end
   end

   // a register write drops back to idle
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         in_frame_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         enable_ff   <= csr_chan.receive_enable;
         in_frame_ff <= 1'b0;
      end else if (load) begin
         in_frame_ff <= in_frame_in;
      end
   end

   rsf_expand u_expand (
      .item          (item_ff),
      .enable        (enable_ff),
      .in_frame      (in_frame_ff),
      .burst         (burst),
      .in_frame_next (in_frame_in)
   );

   rsf_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .burst    (burst),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

/* design/rsf_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module rsf_checker
   import rsf_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] out_byte,
   input wire logic       last_byte,
   input wire logic       flush_read,
   input wire logic       reset_pulse
);

   logic [COUNT_W-1:0] seen_ff;
   logic               pop;

   assign pop = rsp_valid && rsp_ready;

   // count words already sent for the current event
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (pop) begin
         seen_ff <= last_byte ? '0 : seen_ff + COUNT_W'(1);
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_byte))
   `ASSERT_IMPLY(a_burst_len, clock, reset, rsp_valid, seen_ff < COUNT_W'(MAX_BYTES))
   `ASSERT_IMPLY(a_flush_first, clock, reset, rsp_valid && flush_read, seen_ff == '0)
   `ASSERT_IMPLY(a_pulse_last, clock, reset, rsp_valid && reset_pulse, last_byte)

endmodule

bind receive_event_slip_framer_core rsf_checker u_rsf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_byte    (rsp_chan.out_byte),
   .last_byte   (rsp_chan.last_byte),
   .flush_read  (rsp_chan.flush_read),
   .reset_pulse (rsp_chan.reset_pulse)
);

`default_nettype wire
